/* rtl/bcts_pkg.sv */
// Package for the compressed texture texel sampler: widths, command codes,
// shared structs and decode helpers. No dependencies.
package bcts_pkg;
   localparam int MaxDim     = 256;
   localparam int StoreWords = 8192;
   localparam int AddrW      = $clog2(StoreWords);
   localparam int DimW       = $clog2(MaxDim) + 1;
   localparam int CoordW     = $clog2(MaxDim);

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_POINT = 2'd1;
   localparam logic [1:0] CMD_BILIN = 2'd2;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_ALPHA  = 2'd2;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_POINT = 2'd1,
      OP_BILIN = 2'd2,
      OP_FIXED = 2'd3
   } op_type;

   // One classified job handed from the front to the back.
   typedef struct packed {
      op_type                  op;
      logic                    oor;
      logic [AddrW-1:0]        waddr;
      logic [63:0]             wdata;
      logic [3:0][CoordW-1:0]  tx;
      logic [3:0][CoordW-1:0]  ty;
      logic [15:0]             uf;
      logic [15:0]             vf;
   } job_type;

   typedef struct packed {
      logic [15:0] red_level;
      logic [15:0] green_level;
      logic [15:0] blue_level;
      logic [15:0] alpha_level;
      logic        out_of_range;
   } rsp_type;

   function automatic logic [7:0] exp5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] exp6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   // floor(v/3) for v < 766 via reciprocal multiply.
   function automatic logic [7:0] div3(input logic [9:0] v);
      logic [21:0] p;
      p = v * 12'd2731;
      return p[20:13];
   endfunction

   // floor(v/7) for v < 1786.
   function automatic logic [7:0] div7(input logic [10:0] v);
      logic [23:0] p;
      p = v * 13'd4682;
      return p[22:15];
   endfunction

   function automatic logic [7:0] pick_col(input logic [1:0] idx, input logic [7:0] a,
                                           input logic [7:0] b);
      logic [7:0] r;
      case (idx)
         2'd0: r = a;
         2'd1: r = b;
         2'd2: r = div3({1'b0, a, 1'b0} + {2'b0, b});
         default: r = div3({2'b0, a} + {1'b0, b, 1'b0});
      endcase
      return r;
   endfunction

   function automatic logic [7:0] pick_alpha(input logic [2:0] idx, input logic [7:0] a,
                                             input logic [7:0] b);
      logic [2:0]  k;
      logic [10:0] s;
      logic [7:0]  r;
      k = idx - 3'd1;
      s = (3'd7 - k) * a + k * b;
      case (idx)
         3'd0: r = a;
         3'd1: r = b;
         default: r = div7(s);
      endcase
      return r;
   endfunction
endpackage

/* rtl/bcts_if.sv */
// Valid/ready channel interfaces for request and response.
// Depends on bcts_pkg.
interface bcts_req_if (input logic clock);
   logic                       valid;
   logic                       ready;
   logic [1:0]                 cmd;
   logic [bcts_pkg::AddrW-1:0] word_index;
   logic [63:0]                word_data;
   logic [7:0]                 pixel_x;
   logic [7:0]                 pixel_y;
   logic signed [31:0]         u_coord;
   logic signed [31:0]         v_coord;
   modport source (output valid, cmd, word_index, word_data, pixel_x, pixel_y,
                   u_coord, v_coord, input ready);
   modport sink (input valid, cmd, word_index, word_data, pixel_x, pixel_y,
                 u_coord, v_coord, output ready);
endinterface

interface bcts_rsp_if (input logic clock);
   logic        valid;
   logic        ready;
   logic [15:0] red_level;
   logic [15:0] green_level;
   logic [15:0] blue_level;
   logic [15:0] alpha_level;
   logic        out_of_range;
   modport source (output valid, red_level, green_level, blue_level, alpha_level,
                   out_of_range, input ready);
   modport sink (input valid, red_level, green_level, blue_level, alpha_level,
                 out_of_range, output ready);
endinterface

/* rtl/bcts_front.sv */
// Front: register the request, then compute coordinates and classify into a job.
// Depends on bcts_pkg.
module bcts_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [1:0]                 cmd,
   input  logic [bcts_pkg::AddrW-1:0] word_index,
   input  logic [63:0]                word_data,
   input  logic [7:0]                 pixel_x,
   input  logic [7:0]                 pixel_y,
   input  logic [31:0]                u_coord,
   input  logic [31:0]                v_coord,
   input  logic [bcts_pkg::DimW-1:0]  tex_width,
   input  logic [bcts_pkg::DimW-1:0]  tex_height,
   input  logic [bcts_pkg::AddrW:0]   words_used,
   output logic                       job_valid,
   input  logic                       job_ready,
   output bcts_pkg::job_type          job
);
   localparam int CW = bcts_pkg::CoordW;
   localparam int DW = bcts_pkg::DimW;

   logic                       hold_ff, hold_in;
   logic [1:0]                 cmd_ff;
   logic [bcts_pkg::AddrW-1:0] idx_ff;
   logic [63:0]                data_ff;
   logic [7:0]                 px_ff, py_ff;
   logic [15:0]                fu_ff, fv_ff;
   logic [DW+15:0]             prx, pry;
   logic [DW-1:0]              bx, by, x0, y0, x1, y1;
   bcts_pkg::job_type          j;

   assign in_ready  = !hold_ff || job_ready;
   assign job_valid = hold_ff;
   assign hold_in   = in_valid ? 1'b1 : (hold_ff && !job_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
      end
      if (in_valid && in_ready) begin
         cmd_ff  <= cmd;
         idx_ff  <= word_index;
         data_ff <= word_data;
         px_ff   <= pixel_x;
         py_ff   <= pixel_y;
         fu_ff   <= u_coord[15:0];
         fv_ff   <= 16'(-v_coord[15:0]);
      end
   end

   always_comb begin
      prx = fu_ff * tex_width;
      pry = fv_ff * tex_height;
      bx  = prx[DW+15:16];
      by  = pry[DW+15:16];
      x0  = (bx > tex_width - 1'b1) ? tex_width - 1'b1 : bx;
      y0  = (by > tex_height - 1'b1) ? tex_height - 1'b1 : by;
      x1  = (x0 + 1'b1 >= tex_width) ? '0 : x0 + 1'b1;
      y1  = (y0 + 1'b1 >= tex_height) ? '0 : y0 + 1'b1;
      j       = '0;
      j.waddr = idx_ff;
      j.wdata = data_ff;
      j.uf    = prx[15:0];
      j.vf    = pry[15:0];
      case (cmd_ff)
         bcts_pkg::CMD_WRITE: begin
            j.op  = bcts_pkg::OP_WRITE;
            j.oor = ({1'b0, idx_ff} >= words_used);
         end
         bcts_pkg::CMD_POINT: begin
            j.oor = ({1'b0, px_ff} >= tex_width) || ({1'b0, py_ff} >= tex_height);
            j.op  = j.oor ? bcts_pkg::OP_FIXED : bcts_pkg::OP_POINT;
            j.tx[0] = CW'(px_ff);
            j.ty[0] = CW'(py_ff);
         end
         bcts_pkg::CMD_BILIN: begin
            j.op = bcts_pkg::OP_BILIN;
            j.tx[0] = CW'(x0); j.ty[0] = CW'(y0);
            j.tx[1] = CW'(x1); j.ty[1] = CW'(y0);
            j.tx[2] = CW'(x0); j.ty[2] = CW'(y1);
            j.tx[3] = CW'(x1); j.ty[3] = CW'(y1);
         end
         default: j.op = bcts_pkg::OP_FIXED;
      endcase
      job = j;
   end
endmodule

/* rtl/bcts_queue.sv */
// Two-entry job queue between front and back.
// Depends on bcts_pkg.
module bcts_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  bcts_pkg::job_type wr_job,
   output logic              rd_valid,
   input  logic              rd_ready,
   output bcts_pkg::job_type rd_job
);
   bcts_pkg::job_type slot_ff [2];
   logic              wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push, pop;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_job   = slot_ff[rp_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;
   assign wp_in    = wp_ff ^ push;
   assign rp_in    = rp_ff ^ pop;
   assign cnt_in   = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wp_ff] <= wr_job;
   end
endmodule

/* rtl/bcts_back.sv */
// Back: block store, texel decode per tap, weighting and accumulation.
// Depends on bcts_pkg.
module bcts_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      job_valid,
   output logic                      job_ready,
   input  bcts_pkg::job_type         job,
   input  logic [bcts_pkg::DimW-1:0] tex_width,
   input  logic                      has_alpha,
   output logic                      out_valid,
   input  logic                      out_ready,
   output bcts_pkg::rsp_type         out_rsp
);
   localparam int AW = bcts_pkg::AddrW;
   localparam int CW = bcts_pkg::CoordW;

   typedef enum logic [2:0] {
      S_IDLE, S_RDA, S_RDC, S_DEC, S_MUL, S_ACC, S_OUT
   } state_type;

   state_type          st_ff;
   bcts_pkg::job_type  job_ff;
   logic [1:0]         tap_ff;
   logic [63:0]        mem [bcts_pkg::StoreWords];
   logic [63:0]        rd_ff, aw_ff;
   logic [AW-1:0]      raddr;
   logic [AW:0]        blk;
   logic [CW-1:0]      cx, cy;
   logic [3:0]         slot;
   logic [7:0]         cr, cg, cb, ca;
   logic [7:0]         tr_ff, tg_ff, tb_ff, ta_ff;
   logic [32:0]        wt, wt_ff;
   logic [16:0]        iu, iv;
   logic [40:0]        pr_ff, pg_ff, pb_ff, pa_ff;
   logic [42:0]        ar_ff, ag_ff, ab_ff, aa_ff;
   bcts_pkg::rsp_type  rsp_ff;
   logic [42:0]        rnd;

   assign cx    = job_ff.tx[tap_ff];
   assign cy    = job_ff.ty[tap_ff];
   assign blk   = (AW+1)'((cy >> 2) * ((tex_width + 2'd3) >> 2) + (cx >> 2));
   assign slot  = {cy[1:0], cx[1:0]};
   assign iu    = 17'd65536 - {1'b0, job_ff.uf};
   assign iv    = 17'd65536 - {1'b0, job_ff.vf};
   assign job_ready = (st_ff == S_IDLE);
   assign out_valid = (st_ff == S_OUT);
   assign out_rsp   = rsp_ff;
   assign rnd       = 43'd1 << 23;

   always_comb begin
      raddr = has_alpha ? AW'({blk, 1'b0}) : AW'(blk);
      if (st_ff == S_RDC && has_alpha) raddr = AW'({blk, 1'b1});
      cr = bcts_pkg::pick_col(rd_ff[32 + 2*slot +: 2], bcts_pkg::exp5(rd_ff[15:11]),
                              bcts_pkg::exp5(rd_ff[31:27]));
      cg = bcts_pkg::pick_col(rd_ff[32 + 2*slot +: 2], bcts_pkg::exp6(rd_ff[10:5]),
                              bcts_pkg::exp6(rd_ff[26:21]));
      cb = bcts_pkg::pick_col(rd_ff[32 + 2*slot +: 2], bcts_pkg::exp5(rd_ff[4:0]),
                              bcts_pkg::exp5(rd_ff[20:16]));
      ca = has_alpha ? bcts_pkg::pick_alpha(aw_ff[16 + 3*slot +: 3], aw_ff[7:0],
                                            aw_ff[15:8]) : 8'd255;
      case (tap_ff)
         2'd0: wt = 33'(iu * iv);
         2'd1: wt = 33'({16'b0, job_ff.uf} * iv);
         2'd2: wt = 33'(iu * {16'b0, job_ff.vf});
         default: wt = 33'({1'b0, job_ff.uf} * {1'b0, job_ff.vf});
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
      end else begin
         case (st_ff)
            S_IDLE: if (job_valid) begin
               job_ff <= job;
               tap_ff <= 2'd0;
               ar_ff <= '0; ag_ff <= '0; ab_ff <= '0; aa_ff <= '0;
               case (job.op)
                  bcts_pkg::OP_WRITE: begin
                     if (!job.oor) mem[job.waddr] <= job.wdata;
                     rsp_ff <= '{red_level: 16'd0, green_level: 16'd0, blue_level: 16'd0,
                                 alpha_level: 16'd0, out_of_range: job.oor};
                     st_ff <= S_OUT;
                  end
                  bcts_pkg::OP_FIXED: begin
                     rsp_ff <= '{red_level: 16'd0, green_level: 16'd0, blue_level: 16'd0,
                                 alpha_level: 16'd0, out_of_range: job.oor};
                     st_ff <= S_OUT;
                  end
                  default: begin
                     rsp_ff <= '0;
                     st_ff  <= S_RDA;
                  end
               endcase
            end
            S_RDA: begin
               aw_ff <= mem[raddr];
               st_ff <= S_RDC;
            end
            S_RDC: begin
               rd_ff <= mem[raddr];
               st_ff <= S_DEC;
            end
            S_DEC: begin
               tr_ff <= cr; tg_ff <= cg; tb_ff <= cb; ta_ff <= ca;
               wt_ff <= wt;
               if (job_ff.op == bcts_pkg::OP_POINT) begin
                  rsp_ff <= '{red_level: {8'd0, cr}, green_level: {8'd0, cg},
                              blue_level: {8'd0, cb}, alpha_level: {8'd0, ca},
                              out_of_range: 1'b0};
                  st_ff <= S_OUT;
               end else begin
                  st_ff <= S_MUL;
               end
            end
            S_MUL: begin
               pr_ff <= wt_ff * tr_ff; pg_ff <= wt_ff * tg_ff;
               pb_ff <= wt_ff * tb_ff; pa_ff <= wt_ff * ta_ff;
               st_ff <= S_ACC;
            end
            S_ACC: begin
               ar_ff <= ar_ff + 43'(pr_ff); ag_ff <= ag_ff + 43'(pg_ff);
               ab_ff <= ab_ff + 43'(pb_ff); aa_ff <= aa_ff + 43'(pa_ff);
               if (tap_ff == 2'd3) begin
                  st_ff <= S_OUT;
                  rsp_ff <= '{red_level:   16'((ar_ff + 43'(pr_ff) + rnd) >> 24),
                              green_level: 16'((ag_ff + 43'(pg_ff) + rnd) >> 24),
                              blue_level:  16'((ab_ff + 43'(pb_ff) + rnd) >> 24),
                              alpha_level: 16'((aa_ff + 43'(pa_ff) + rnd) >> 24),
                              out_of_range: 1'b0};
               end else begin
                  tap_ff <= tap_ff + 2'd1;
                  st_ff  <= S_RDA;
               end
            end
            S_OUT: if (out_ready) st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* rtl/bc_texture_texel_sampler_top.sv */
// Top level of the compressed texture texel sampler: config registers, front,
// job queue and back. Depends on bcts_pkg, bcts_if, bcts_front, bcts_queue, bcts_back.
//
//   channel  direction  handshake      payload
//   req      in         valid/ready    cmd, word_index, word_data, pixel_x/y, u/v_coord
//   rsp      out        valid/ready    red/green/blue/alpha_level, out_of_range
//   csr      in         write enable   index, 9-bit data
//
// In the back a write or out-of-range item goes straight to output; a point fetch
// reads the alpha word, then the colour word, decodes and outputs; a bilinear sample
// does so for each of 4 taps, multiplying and accumulating, then outputs: the single
// store port (alpha word then colour word per tap) sets the pace. Reset is synchronous
// and clears control state; the store holds garbage until written. The front register
// and two-entry queue let requests land while the back is busy or a response waits.
module bc_texture_texel_sampler_top (
   input  logic              clock,
   input  logic              reset,
   bcts_req_if.sink          req,
   bcts_rsp_if.source        rsp,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [8:0]        csr_data
);
   localparam int DW = bcts_pkg::DimW;

   logic [DW-1:0]            width_ff, height_ff;
   logic                     alpha_ff;
   logic [DW-1:0]            clamped;
   logic [bcts_pkg::AddrW:0] words_used;
   logic [13:0]              nblk;
   logic                     fj_valid, fj_ready, bj_valid, bj_ready;
   bcts_pkg::job_type        fj, bj;
   bcts_pkg::rsp_type        r;

   // Clamp dimension writes into 1..MaxDim.
   always_comb begin
      if (csr_data == 9'd0) clamped = DW'(1);
      else if (csr_data > 9'(bcts_pkg::MaxDim)) clamped = DW'(bcts_pkg::MaxDim);
      else clamped = DW'(csr_data);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= DW'(4); height_ff <= DW'(4); alpha_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            bcts_pkg::REG_WIDTH:  width_ff  <= clamped;
            bcts_pkg::REG_HEIGHT: height_ff <= clamped;
            bcts_pkg::REG_ALPHA:  alpha_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Words the texture occupies; never more than the store holds at MaxDim=256.
   assign nblk = 14'(((width_ff + 2'd3) >> 2) * ((height_ff + 2'd3) >> 2));
   assign words_used = (bcts_pkg::AddrW+1)'(nblk << alpha_ff);

   bcts_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .cmd(req.cmd),
      .word_index(req.word_index), .word_data(req.word_data),
      .pixel_x(req.pixel_x), .pixel_y(req.pixel_y),
      .u_coord(req.u_coord), .v_coord(req.v_coord),
      .tex_width(width_ff), .tex_height(height_ff), .words_used,
      .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
   );

   bcts_queue u_queue (
      .clock, .reset,
      .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
      .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
   );

   bcts_back u_back (
      .clock, .reset,
      .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
      .tex_width(width_ff), .has_alpha(alpha_ff),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_rsp(r)
   );

   assign rsp.red_level    = r.red_level;
   assign rsp.green_level  = r.green_level;
   assign rsp.blue_level   = r.blue_level;
   assign rsp.alpha_level  = r.alpha_level;
   assign rsp.out_of_range = r.out_of_range;
endmodule
